// ===== rtl/core/b64sc_pkg.sv =====
// ----------------------------------------------------------------------------
// b64sc_pkg
// Shared types, constants and alphabet functions of the base64 stream codec.
// ----------------------------------------------------------------------------
package b64sc_pkg;

    // up to four results come out of one item (last byte of a one-byte group)
    localparam int MaxResults = 4;
    localparam int IdxW       = $clog2(MaxResults);
    localparam int CntW       = $clog2(MaxResults + 1);

    localparam logic [7:0] PadChar = 8'h3D;

    typedef enum logic {
        MODE_ENCODE = 1'b0,
        MODE_DECODE = 1'b1
    } mode_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       has_char;
        logic       end_of_run;
    } result_t;

    // all results caused by one item, in output order
    typedef struct packed {
        result_t [MaxResults-1:0] entry;
        logic [CntW-1:0]          count;
    } burst_t;

    typedef struct packed {
        logic [1:0] group_phase;
        logic [5:0] carry_bits;
        logic       pad_seen;
    } codec_state_t;

    // status of the result buffer, seen by the top level
    typedef struct packed {
        logic can_load;
        logic final_entry;
    } burst_status_t;

    // 6-bit value to alphabet character
    function automatic logic [7:0] enc_char(input logic [5:0] v);
        logic [7:0] c;
        if (v < 6'd26) begin
            c = 8'h41 + {2'b00, v};
        end
        else if (v < 6'd52) begin
            c = 8'h61 + {2'b00, v} - 8'd26;
        end
        else if (v < 6'd62) begin
            c = 8'h30 + {2'b00, v} - 8'd52;
        end
        else if (v == 6'd62) begin
            c = 8'h2B;
        end
        else begin
            c = 8'h2F;
        end
        return c;
    endfunction

    // alphabet character to 6-bit value, anything else maps to zero
    function automatic logic [5:0] dec_value(input logic [7:0] c);
        logic [7:0] v;
        if (c >= 8'h41 && c <= 8'h5A) begin
            v = c - 8'h41;
        end
        else if (c >= 8'h61 && c <= 8'h7A) begin
            v = c - 8'h61 + 8'd26;
        end
        else if (c >= 8'h30 && c <= 8'h39) begin
            v = c - 8'h30 + 8'd52;
        end
        else if (c == 8'h2B) begin
            v = 8'd62;
        end
        else if (c == 8'h2F) begin
            v = 8'd63;
        end
        else begin
            v = 8'd0;
        end
        return v[5:0];
    endfunction

endpackage

// ===== rtl/core/b64sc_in_if.sv =====
// ----------------------------------------------------------------------------
// b64sc_in_if
// Valid/ready channel that carries input items into the codec.
// ----------------------------------------------------------------------------
interface b64sc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_char;
    logic       last_item;

    modport source (output valid, output in_char, output last_item, input ready);
    modport sink   (input valid, input in_char, input last_item, output ready);
endinterface

// ===== rtl/core/b64sc_out_if.sv =====
// ----------------------------------------------------------------------------
// b64sc_out_if
// Valid/ready channel that carries result items out of the codec.
// ----------------------------------------------------------------------------
interface b64sc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       has_char;
    logic       end_of_run;

    modport source (output valid, output out_char, output has_char, output end_of_run,
                    input ready);
    modport sink   (input valid, input out_char, input has_char, input end_of_run,
                    output ready);
endinterface

// ===== rtl/core/base64_stream_codec.sv =====
// ----------------------------------------------------------------------------
// base64_stream_codec
// Base64 encoder/decoder over a byte stream, standard alphabet with padding.
// ----------------------------------------------------------------------------
// output: first result of an item is offered in the cycle after the item is taken
// throughput: one item per cycle while each item gives at most one result and the
//   result port is not stalled; an item with more results holds the single result port
//   until all of its results have left
// reset: mode goes to encode, group state clears, result buffer empties
module base64_stream_codec (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        mode_we,
    input  logic        mode_wdata,
    b64sc_in_if.sink    item_chan,
    b64sc_out_if.source result_chan
);

    // mode register; the user must write it only while the codec is idle, the block does not enforce this
    b64sc_pkg::mode_t        mode_reg;
    // group state carried from one item to the next
    b64sc_pkg::codec_state_t state_reg;
    b64sc_pkg::codec_state_t state_next;

    b64sc_pkg::burst_t        item_burst;
    b64sc_pkg::burst_status_t burst_status;
    logic                     accept;

    // a new item is taken when the buffer is empty or its last result leaves now
    assign item_chan.ready = burst_status.can_load;
    assign accept          = item_chan.valid && item_chan.ready;

    // per-item combinational work: results and next group state
    b64sc_step u_step (
        .mode      (mode_reg),
        .cur       (state_reg),
        .in_char   (item_chan.in_char),
        .last_item (item_chan.last_item),
        .nxt       (state_next),
        .burst     (item_burst)
    );

    // result buffer that drains one result per cycle while the result port is ready
    b64sc_burst u_burst (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (accept),
        .load_burst  (item_burst),
        .status      (burst_status),
        .result_chan (result_chan)
    );

    // a mode write also restarts the group
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg  <= b64sc_pkg::MODE_ENCODE;
            state_reg <= '0;
        end
        else if (mode_we) begin
            mode_reg  <= b64sc_pkg::mode_t'(mode_wdata);
            state_reg <= '0;
        end
        else if (accept) begin
            state_reg <= state_next;
        end
    end

    // end of run only ever leaves with the last buffered result
    assert property (@(posedge clk) disable iff (!rst_n)
        result_chan.valid && result_chan.end_of_run |-> burst_status.final_entry)
        else $error("end_of_run on a result that is not the last of its item");

    // encoding never gives a bare end marker
    assert property (@(posedge clk) disable iff (!rst_n)
        result_chan.valid && mode_reg == b64sc_pkg::MODE_ENCODE |-> result_chan.has_char)
        else $error("encode result without a character");

    // the final item of a message leaves the group state cleared
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && item_chan.last_item |=> state_reg == '0)
        else $error("group state not cleared after the last item");

    // an empty result buffer always takes the next item
    assert property (@(posedge clk) disable iff (!rst_n)
        !result_chan.valid |-> item_chan.ready)
        else $error("input stalled while no result is pending");

endmodule

// ===== rtl/core/b64sc_step.sv =====
// ----------------------------------------------------------------------------
// b64sc_step
// Per-item codec logic: results of one item and the next group state.
// ----------------------------------------------------------------------------
module b64sc_step (
    input  b64sc_pkg::mode_t        mode,
    input  b64sc_pkg::codec_state_t cur,
    input  logic [7:0]              in_char,
    input  logic                    last_item,
    output b64sc_pkg::codec_state_t nxt,
    output b64sc_pkg::burst_t       burst
);

    always_comb
    begin
        logic [b64sc_pkg::CntW-1:0] n;
        logic [5:0]                 v;
        b64sc_pkg::codec_state_t    s;

        n     = '0;
        s     = cur;
        v     = b64sc_pkg::dec_value(in_char);
        burst = '0;

        if (mode == b64sc_pkg::MODE_ENCODE) begin
            case (cur.group_phase)
                2'd0:
                begin
                    burst.entry[n[b64sc_pkg::IdxW-1:0]] =
                        '{b64sc_pkg::enc_char(in_char[7:2]), 1'b1, 1'b0};
                    n = n + b64sc_pkg::CntW'(1);
                    s.carry_bits  = {in_char[1:0], 4'b0000};
                    s.group_phase = 2'd1;
                end
                2'd1:
                begin
                    burst.entry[n[b64sc_pkg::IdxW-1:0]] =
                        '{b64sc_pkg::enc_char({cur.carry_bits[5:4], in_char[7:4]}), 1'b1, 1'b0};
                    n = n + b64sc_pkg::CntW'(1);
                    s.carry_bits  = {in_char[3:0], 2'b00};
                    s.group_phase = 2'd2;
                end
                default:
                begin
                    burst.entry[n[b64sc_pkg::IdxW-1:0]] =
                        '{b64sc_pkg::enc_char({cur.carry_bits[5:2], in_char[7:6]}), 1'b1, 1'b0};
                    n = n + b64sc_pkg::CntW'(1);
                    burst.entry[n[b64sc_pkg::IdxW-1:0]] =
                        '{b64sc_pkg::enc_char(in_char[5:0]), 1'b1, 1'b0};
                    n = n + b64sc_pkg::CntW'(1);
                    s.carry_bits  = '0;
                    s.group_phase = 2'd0;
                end
            endcase
            if (last_item) begin
                // flush leftover bits, then pad the group out to four
                if (s.group_phase != 2'd0) begin
                    burst.entry[n[b64sc_pkg::IdxW-1:0]] =
                        '{b64sc_pkg::enc_char(s.carry_bits), 1'b1, 1'b0};
                    n = n + b64sc_pkg::CntW'(1);
                    burst.entry[n[b64sc_pkg::IdxW-1:0]] = '{b64sc_pkg::PadChar, 1'b1, 1'b0};
                    n = n + b64sc_pkg::CntW'(1);
                end
                if (s.group_phase == 2'd1) begin
                    burst.entry[n[b64sc_pkg::IdxW-1:0]] = '{b64sc_pkg::PadChar, 1'b1, 1'b0};
                    n = n + b64sc_pkg::CntW'(1);
                end
            end
        end
        else begin
            if (in_char == b64sc_pkg::PadChar) begin
                s.pad_seen = 1'b1;
            end
            else if (!cur.pad_seen) begin
                case (cur.group_phase)
                    2'd0:
                    begin
                        s.carry_bits  = v;
                        s.group_phase = 2'd1;
                    end
                    2'd1:
                    begin
                        burst.entry[n[b64sc_pkg::IdxW-1:0]] =
                            '{{cur.carry_bits, v[5:4]}, 1'b1, 1'b0};
                        n = n + b64sc_pkg::CntW'(1);
                        s.carry_bits  = {2'b00, v[3:0]};
                        s.group_phase = 2'd2;
                    end
                    2'd2:
                    begin
                        burst.entry[n[b64sc_pkg::IdxW-1:0]] =
                            '{{cur.carry_bits[3:0], v[5:2]}, 1'b1, 1'b0};
                        n = n + b64sc_pkg::CntW'(1);
                        s.carry_bits  = {4'b0000, v[1:0]};
                        s.group_phase = 2'd3;
                    end
                    default:
                    begin
                        burst.entry[n[b64sc_pkg::IdxW-1:0]] =
                            '{{cur.carry_bits[1:0], v}, 1'b1, 1'b0};
                        n = n + b64sc_pkg::CntW'(1);
                        s.carry_bits  = '0;
                        s.group_phase = 2'd0;
                    end
                endcase
            end
            if (last_item && n == '0) begin
                // bare end marker
                burst.entry[n[b64sc_pkg::IdxW-1:0]] = '{8'h00, 1'b0, 1'b0};
                n = n + b64sc_pkg::CntW'(1);
            end
        end

        if (last_item) begin
            burst.entry[b64sc_pkg::IdxW'(n - b64sc_pkg::CntW'(1))].end_of_run = 1'b1;
            s = '0;
        end

        burst.count = n;
        nxt         = s;
    end

endmodule

// ===== rtl/core/b64sc_burst.sv =====
// ----------------------------------------------------------------------------
// b64sc_burst
// Result buffer: holds the results of one item and sends them out in order.
// ----------------------------------------------------------------------------
module b64sc_burst (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     load,
    input  b64sc_pkg::burst_t        load_burst,
    output b64sc_pkg::burst_status_t status,
    b64sc_out_if.source              result_chan
);

    b64sc_pkg::result_t [b64sc_pkg::MaxResults-1:0] entry_reg;
    logic [b64sc_pkg::CntW-1:0]                     count_reg;
    logic [b64sc_pkg::IdxW-1:0]                     idx_reg;

    logic take;
    logic last_take;
    logic final_entry;

    assign final_entry = ({1'b0, idx_reg} == count_reg - b64sc_pkg::CntW'(1));
    assign take        = result_chan.valid && result_chan.ready;
    assign last_take   = take && final_entry;

    assign status.can_load    = (count_reg == '0) || last_take;
    assign status.final_entry = final_entry;

    assign result_chan.valid      = (count_reg != '0);
    assign result_chan.out_char   = entry_reg[idx_reg].out_char;
    assign result_chan.has_char   = entry_reg[idx_reg].has_char;
    assign result_chan.end_of_run = entry_reg[idx_reg].end_of_run;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            count_reg <= '0;
            idx_reg   <= '0;
        end
        else if (load) begin
            count_reg <= load_burst.count;
            idx_reg   <= '0;
        end
        else if (last_take) begin
            count_reg <= '0;
            idx_reg   <= '0;
        end
        else if (take) begin
            idx_reg <= idx_reg + b64sc_pkg::IdxW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            entry_reg <= load_burst.entry;
        end
    end

endmodule
